// File: rtl/bdj_pkg.sv
// Shared types, register indexes and defaults for the button debounce and joystick front end.
package bdj_pkg;

    localparam int BUTTON_COUNT_DEF   = 7;
    localparam int ADC_FULL_SCALE_DEF = 4095;

    // Width of the pin, acknowledge and button mask fields on the ports.
    localparam int PIN_W = 7;
    localparam int ADC_W = 12;
    localparam int PCT_W = 8;

    localparam int PCT_FULL    = 100;
    localparam int PCT_OVER    = 101;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_POSITIVE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PINS_ACTIVE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HELD_ENABLE      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE     = 3'd7;

    typedef struct packed {
        logic [15:0]      debounce_time;
        logic [ADC_W-1:0] dead_zone;
        logic [ADC_W-1:0] center_x;
        logic [ADC_W-1:0] center_y;
        logic             forward_positive;
        logic             pins_active_low;
        logic [PIN_W-1:0] held_enable;
        logic [PIN_W-1:0] event_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_time:    16'd30,
        dead_zone:        12'd100,
        center_x:         12'd2048,
        center_y:         12'd2048,
        forward_positive: 1'b1,
        pins_active_low:  1'b1,
        held_enable:      7'd112,
        event_enable:     7'd31
    };

    // Input item as packed on s_tdata, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]       pad;
        logic [PIN_W-1:0] ack_mask;
        logic [ADC_W-1:0] stick_y_raw;
        logic [ADC_W-1:0] stick_x_raw;
        logic [PIN_W-1:0] raw_pins;
        logic [31:0]      now_ms;
    } in_item_t;

    // Result item as packed on m_tdata.
    typedef struct packed {
        logic [1:0]       pad;
        logic [PIN_W-1:0] edge_events;
        logic [PIN_W-1:0] held_buttons;
        logic [PCT_W-1:0] stick_y;
        logic [PCT_W-1:0] stick_x;
    } out_item_t;

    localparam int IN_DATA_W  = $bits(in_item_t);
    localparam int OUT_DATA_W = $bits(out_item_t);

    // What the front part hands to the back part for one item.
    typedef struct packed {
        logic [ADC_W-1:0] stick_x_raw;
        logic [ADC_W-1:0] stick_y_raw;
        logic [PIN_W-1:0] held_buttons;
        logic [PIN_W-1:0] edge_events;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: rtl/bdj_front.sv
// Front part: takes input items, clears acknowledged events and debounces the buttons.
module bdj_front #(
    parameter int BUTTON_COUNT = bdj_pkg::BUTTON_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdj_pkg::cfg_t                  cfg,
    input  logic                           s_tvalid,
    // s_tdata: now_ms, raw_pins, stick_x_raw, stick_y_raw, ack_mask, zero pad
    input  logic [bdj_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           s_tready,
    input  bdj_pkg::q_stat_t               q_stat,
    output logic                           q_push,
    output bdj_pkg::entry_t                q_entry
);

    localparam int VEC_W = (BUTTON_COUNT > bdj_pkg::PIN_W) ? BUTTON_COUNT : bdj_pkg::PIN_W;

    bdj_pkg::in_item_t item;

    logic [BUTTON_COUNT-1:0] last_raw_reg, last_raw_next;
    logic [BUTTON_COUNT-1:0] stable_reg, stable_next;
    logic [BUTTON_COUNT-1:0] pending_reg, pending_next;
    logic [31:0]             change_time_reg [BUTTON_COUNT];
    logic [31:0]             change_time_next [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] settle;
    logic [BUTTON_COUNT-1:0] set_event;

    logic [VEC_W-1:0] pins_pad, ack_pad, event_en_pad, stable_pad, pending_pad;

    logic accept;

    assign item     = bdj_pkg::in_item_t'(s_tdata);
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pins_pad     = VEC_W'(item.raw_pins);
        ack_pad      = VEC_W'(item.ack_mask);
        event_en_pad = VEC_W'(cfg.event_enable);
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            // An active level is the pin level, inverted for active-low pins.
            last_raw_next[i] = pins_pad[i] ^ cfg.pins_active_low;
            change_time_next[i] = (last_raw_next[i] != last_raw_reg[i]) ?
                                  item.now_ms : change_time_reg[i];
            settle[i] = (stable_reg[i] != last_raw_next[i]) &&
                        ((item.now_ms - change_time_next[i]) >= 32'(cfg.debounce_time));
            stable_next[i] = settle[i] ? last_raw_next[i] : stable_reg[i];
            set_event[i]   = settle[i] && last_raw_next[i] && event_en_pad[i];
        end
        pending_next = (pending_reg & ~ack_pad[BUTTON_COUNT-1:0]) | set_event;
        stable_pad   = VEC_W'(stable_next);
        pending_pad  = VEC_W'(pending_next);
    end

    assign q_push = accept;

    always_comb begin
        q_entry.stick_x_raw  = item.stick_x_raw;
        q_entry.stick_y_raw  = item.stick_y_raw;
        q_entry.held_buttons = stable_pad[bdj_pkg::PIN_W-1:0] & cfg.held_enable;
        q_entry.edge_events  = pending_pad[bdj_pkg::PIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg <= '0;
            stable_reg   <= '0;
            pending_reg  <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                change_time_reg[i] <= '0;
            end
        end else if (accept) begin
            last_raw_reg <= last_raw_next;
            stable_reg   <= stable_next;
            pending_reg  <= pending_next;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

endmodule

// File: rtl/bdj_queue.sv
// Short first-in first-out queue of items between the front and back parts.
module bdj_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  bdj_pkg::q_ctrl_t ctrl,
    input  bdj_pkg::entry_t  wr_entry,
    output bdj_pkg::q_stat_t stat,
    output bdj_pkg::entry_t  rd_entry
);

    localparam int DEPTH = bdj_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdj_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rd_entry   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bdj_back.sv
// Back part: scales both joystick axes through one serial divider and drives the result.
module bdj_back #(
    parameter int ADC_FULL_SCALE = bdj_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdj_pkg::cfg_t                  cfg,
    input  bdj_pkg::q_stat_t               q_stat,
    input  bdj_pkg::entry_t                q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: stick_x, stick_y, held_buttons, edge_events, zero pad
    output logic [bdj_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
    localparam int RW   = (FS_W > bdj_pkg::ADC_W) ? FS_W : bdj_pkg::ADC_W;
    localparam int SW   = RW + 2;
    localparam int NW   = RW + 7;
    localparam int AW   = bdj_pkg::ADC_W;
    localparam int QW   = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_TEST,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    bdj_pkg::entry_t           ent_reg;
    logic                      axis_reg;
    logic [NW-1:0]             num_reg;
    logic [RW-1:0]             den_reg;
    logic                      neg_reg;
    logic [NW-1:0]             rem_reg;
    logic [QW-1:0]             q_reg;
    logic [2:0]                bit_reg;
    logic [bdj_pkg::PCT_W-1:0] x_res_reg;
    logic [bdj_pkg::PCT_W-1:0] y_res_reg;
    logic                      m_tvalid_reg;
    bdj_pkg::out_item_t        m_item_reg;

    logic [AW-1:0]        raw, center;
    logic signed [AW:0]   delta, delta_neg;
    logic [AW-1:0]        mag;
    logic                 delta_pos;
    logic signed [SW-1:0] range_s, dz_s, den_s;
    logic                 zero_out;
    logic [NW-1:0]        num_calc;
    logic [NW-1:0]        den_over;
    logic [NW-1:0]        den_shift;
    logic                 sign_out;
    logic [bdj_pkg::PCT_W-1:0] pct_ext, pct_val;

    always_comb begin
        raw       = axis_reg ? ent_reg.stick_y_raw : ent_reg.stick_x_raw;
        center    = axis_reg ? cfg.center_y : cfg.center_x;
        delta     = $signed({1'b0, raw}) - $signed({1'b0, center});
        delta_neg = -delta;
        mag       = delta[AW] ? delta_neg[AW-1:0] : delta[AW-1:0];
        delta_pos = !delta[AW] && (delta != '0);
        dz_s      = $signed(SW'(cfg.dead_zone));
        // Range runs from the centre to the end of the scale on the side of the deviation.
        range_s   = delta_pos ? $signed(SW'(ADC_FULL_SCALE)) - $signed(SW'(center))
                              : $signed(SW'(center));
        den_s     = range_s - dz_s;
        zero_out  = (mag <= cfg.dead_zone) || (range_s <= dz_s);
        num_calc  = NW'(mag - cfg.dead_zone) * NW'(bdj_pkg::PCT_FULL);
    end

    assign den_over  = NW'(den_reg) * NW'(bdj_pkg::PCT_OVER);
    assign den_shift = NW'(den_reg) << bit_reg;

    always_comb begin
        sign_out = neg_reg ^ (axis_reg && !cfg.forward_positive);
        pct_ext  = bdj_pkg::PCT_W'(q_reg);
        pct_val  = sign_out ? (~pct_ext + 1'b1) : pct_ext;
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In the emit state the result register is handled by that state alone.
            if (m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        ent_reg   <= q_entry;
                        axis_reg  <= 1'b0;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    num_reg <= num_calc;
                    den_reg <= den_s[RW-1:0];
                    neg_reg <= delta[AW];
                    if (zero_out) begin
                        q_reg     <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    // Past 100 percent the result clamps; below it the quotient has 7 bits.
                    if (num_reg >= den_over) begin
                        q_reg     <= QW'(bdj_pkg::PCT_FULL);
                        state_reg <= ST_FIN;
                    end else begin
                        q_reg     <= '0;
                        rem_reg   <= num_reg;
                        bit_reg   <= 3'(QW - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_reg >= den_shift) begin
                        rem_reg        <= rem_reg - den_shift;
                        q_reg[bit_reg] <= 1'b1;
                    end
                    if (bit_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                ST_FIN: begin
                    if (!axis_reg) begin
                        x_res_reg <= pct_val;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_PREP;
                    end else begin
                        y_res_reg <= pct_val;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_item_reg.pad          <= '0;
                        m_item_reg.stick_x      <= x_res_reg;
                        m_item_reg.stick_y      <= y_res_reg;
                        m_item_reg.held_buttons <= ent_reg.held_buttons;
                        m_item_reg.edge_events  <= ent_reg.edge_events;
                        m_tvalid_reg            <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/button_debounce_joystick_frontend.sv
// Flow: the back part takes an item from the queue, then per axis runs a setup, a clamp test,
// 7 restoring steps of the serial divider that both axes share and a sign step (only setup,
// test and sign when clamped, setup and sign in the dead zone), and then drives the result,
// waiting while the earlier result is not yet taken; only then does it take the next item.
// The front part accepts items while the two-entry queue has room. Reset (synchronous, active
// low) restores register defaults and sets every button inactive with no pending events.
module button_debounce_joystick_frontend #(
    parameter int BUTTON_COUNT   = bdj_pkg::BUTTON_COUNT_DEF,
    parameter int ADC_FULL_SCALE = bdj_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdj_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdj_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: now_ms, raw_pins, stick_x_raw, stick_y_raw, ack_mask, zero pad
    input  logic [bdj_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: stick_x, stick_y, held_buttons, edge_events, zero pad
    output logic [bdj_pkg::OUT_DATA_W-1:0]  m_tdata
);

    bdj_pkg::cfg_t    cfg_reg;
    bdj_pkg::q_ctrl_t q_ctrl;
    bdj_pkg::q_stat_t q_stat;
    bdj_pkg::entry_t  wr_entry, rd_entry;
    logic             q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        q_ctrl.push = q_push;
        q_ctrl.pop  = q_pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bdj_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bdj_pkg::REG_DEBOUNCE_TIME:    cfg_reg.debounce_time    <= cfg_data;
                bdj_pkg::REG_DEAD_ZONE:        cfg_reg.dead_zone        <= cfg_data[11:0];
                bdj_pkg::REG_CENTER_X:         cfg_reg.center_x         <= cfg_data[11:0];
                bdj_pkg::REG_CENTER_Y:         cfg_reg.center_y         <= cfg_data[11:0];
                bdj_pkg::REG_FORWARD_POSITIVE: cfg_reg.forward_positive <= cfg_data[0];
                bdj_pkg::REG_PINS_ACTIVE_LOW:  cfg_reg.pins_active_low  <= cfg_data[0];
                bdj_pkg::REG_HELD_ENABLE:      cfg_reg.held_enable      <= cfg_data[6:0];
                bdj_pkg::REG_EVENT_ENABLE:     cfg_reg.event_enable     <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    bdj_front #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tready (s_tready),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (wr_entry)
    );

    bdj_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (q_ctrl),
        .wr_entry (wr_entry),
        .stat     (q_stat),
        .rd_entry (rd_entry)
    );

    bdj_back #(
        .ADC_FULL_SCALE(ADC_FULL_SCALE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .q_entry  (rd_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
